FILE: rtl/core/tmexp_pkg.sv
package tmexp_pkg;

    localparam int STAMP_W = 32;
    localparam int DUR_W   = 31;
    localparam int DELTA_W = 16;
    localparam int KIND_W  = 3;
    localparam int KEY_W   = 16;
    localparam int OCC_W   = 5;
    localparam int ACT_W   = 2;

    // action codes
    localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ADD   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CHECK = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [DELTA_W-1:0] time_delta;
        logic [KIND_W-1:0]  input_kind;
        logic [KEY_W-1:0]   key_code;
    } in_item_t;

    typedef struct packed {
        logic             head_matched;
        logic             add_dropped;
        logic [OCC_W-1:0] occupancy;
    } out_item_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [KEY_W-1:0]   key;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic push;
        logic pop;
        logic clear;
        logic set_match;
        logic set_drop;
        logic load_result;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             full;
        logic             expire;
        logic             head_hit;
    } status_t;

endpackage

FILE: rtl/core/tmexp_ram.sv
module tmexp_ram #(
    parameter int WIDTH = 51,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/core/tmexp_ctrl.sv
module tmexp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  tmexp_pkg::status_t status,
    output tmexp_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                case (status.action)
                    tmexp_pkg::ACT_TICK:
                    begin
                        // one expired head leaves per cycle
                        if (status.expire)
                        begin
                            cmd.pop    = 1'b1;
                            state_next = S_EXEC;
                        end
                    end
                    tmexp_pkg::ACT_ADD:
                    begin
                        if (status.full)
                        begin
                            cmd.set_drop = 1'b1;
                        end
                        else
                        begin
                            cmd.push = 1'b1;
                        end
                    end
                    tmexp_pkg::ACT_CHECK:
                    begin
                        if (status.head_hit)
                        begin
                            cmd.pop       = 1'b1;
                            cmd.set_match = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.clear = 1'b1;
                    end
                endcase
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.load_result = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/core/tmexp_dp.sv
module tmexp_dp #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tmexp_pkg::in_item_t           in_data,
    input  logic                          cfg_valid,
    input  logic [tmexp_pkg::DUR_W-1:0]   cfg_data,
    input  tmexp_pkg::cmd_t               cmd,
    output tmexp_pkg::status_t            status,
    output tmexp_pkg::out_item_t          out_data
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IW-1:0] LAST_SLOT = IW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);

    tmexp_pkg::in_item_t             item_reg;
    tmexp_pkg::out_item_t            out_data_reg;
    tmexp_pkg::entry_t               wr_entry;
    tmexp_pkg::entry_t               head_entry;
    logic [tmexp_pkg::STAMP_W-1:0]   now_reg;
    logic [tmexp_pkg::STAMP_W-1:0]   now_next;
    logic [tmexp_pkg::STAMP_W-1:0]   age;
    logic [tmexp_pkg::DUR_W-1:0]     dur_reg;
    logic [IW-1:0]                   head_reg;
    logic [IW-1:0]                   head_next;
    logic [IW-1:0]                   tail_reg;
    logic [IW-1:0]                   tail_next;
    logic [CW-1:0]                   count_reg;
    logic [CW-1:0]                   count_next;
    logic                            match_reg;
    logic                            drop_reg;

    function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] idx);
        next_slot = (idx == LAST_SLOT) ? '0 : idx + 1'b1;
    endfunction

    assign wr_entry.kind  = item_reg.input_kind;
    assign wr_entry.key   = item_reg.key_code;
    assign wr_entry.stamp = now_reg;

    // read address follows the next head, so the registered read data tracks the head pointer
    tmexp_ram #(
        .WIDTH ($bits(tmexp_pkg::entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr (tail_reg),
        .wr_data (wr_entry),
        .rd_addr (head_next),
        .rd_data (head_entry)
    );

    always_comb
    begin
        now_next   = now_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.load_item && (in_data.action == tmexp_pkg::ACT_TICK))
        begin
            now_next = now_reg + tmexp_pkg::STAMP_W'(in_data.time_delta);
        end
        if (cmd.clear)
        begin
            now_next   = '0;
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
        else if (cmd.push)
        begin
            tail_next  = next_slot(tail_reg);
            count_next = count_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            head_next  = next_slot(head_reg);
            count_next = count_reg - 1'b1;
        end
    end

    // modular age of the head entry
    assign age = now_reg - head_entry.stamp;

    assign status.action   = item_reg.action;
    assign status.full     = (count_reg == FULL_CNT);
    assign status.expire   = (count_reg != '0) && (age > {1'b0, dur_reg});
    assign status.head_hit = (count_reg != '0)
                             && (head_entry.kind == item_reg.input_kind)
                             && (head_entry.key == item_reg.key_code);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg   <= '0;
            dur_reg   <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            match_reg <= 1'b0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            now_reg   <= now_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (cfg_valid)
            begin
                dur_reg <= cfg_data;
            end
            if (cmd.load_item)
            begin
                match_reg <= 1'b0;
                drop_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.set_match)
                begin
                    match_reg <= 1'b1;
                end
                if (cmd.set_drop)
                begin
                    drop_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_data;
        end
        if (cmd.load_result)
        begin
            out_data_reg.head_matched <= match_reg;
            out_data_reg.add_dropped  <= drop_reg;
            out_data_reg.occupancy    <= tmexp_pkg::OCC_W'(count_reg);
        end
    end

    assign out_data = out_data_reg;

endmodule

FILE: rtl/core/timed_input_expiry_fifo.sv
// add, check and clear pass the accept, execute and result states; the result beat is registered
// a tick stays in execute while it expires entries (one per cycle, at most depth)
// one item in flight: a new item is taken only after the last result is loaded
// into the result register
// reset: rst_n async active low clears time, pointers, count and buffer_duration;
// entry memory is not cleared and is only read behind the entry count
module timed_input_expiry_fifo #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input beats
    input  logic                          in_valid,
    output logic                          in_ready,
    input  tmexp_pkg::in_item_t           in_data,
    // result beats
    output logic                          out_valid,
    input  logic                          out_ready,
    output tmexp_pkg::out_item_t          out_data,
    // buffer_duration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tmexp_pkg::DUR_W-1:0]   cfg_data
);

    tmexp_pkg::cmd_t    cmd;
    tmexp_pkg::status_t status;

    // duration register takes a beat in any cycle
    assign cfg_ready = 1'b1;

    // sequencer: accept, execute (expiry loop stays here), hand over result
    tmexp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // time accumulator, ring pointers, entry memory and result register
    tmexp_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

endmodule

FILE: rtl/core/tmexp_checker.sv
module tmexp_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input tmexp_pkg::out_item_t out_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // one item in flight: no input beat right after another
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    // a result never flags both match and drop
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.head_matched && out_data.add_dropped))
        else $error("match and drop both set");

    // a dropped add only happens on a full queue
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.add_dropped
            |-> out_data.occupancy == tmexp_pkg::OCC_W'(QUEUE_DEPTH))
        else $error("drop without full queue");

    // occupancy stays within depth
    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (QUEUE_DEPTH > 31)
            || (out_data.occupancy <= tmexp_pkg::OCC_W'(QUEUE_DEPTH)))
        else $error("occupancy above depth");

endmodule

bind timed_input_expiry_fifo tmexp_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_tmexp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

FILE: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 300000;
    localparam int IDLE_PCT    = 26;
    localparam int HOLD_CYCLES = 400;
    // wait after the last result, sized from a tick that walks the whole queue
    localparam int TAIL_CYCLES = 2 + QUEUE_DEPTH + 20;
    localparam logic [tmexp_pkg::DUR_W-1:0] DUR_MAX = '1;

    // predicts the status beat of every accepted item and checks the block against it
    class expiry_scoreboard;
        logic [tmexp_pkg::DUR_W-1:0]   duration;
        logic [tmexp_pkg::STAMP_W-1:0] now_time;
        tmexp_pkg::entry_t             slots [QUEUE_DEPTH];
        int unsigned                   head;
        int unsigned                   tail;
        int unsigned                   count;
        tmexp_pkg::out_item_t          pending_status [$];
        int                            fail_count;

        function new();
            duration   = '0;
            now_time   = '0;
            head       = 0;
            tail       = 0;
            count      = 0;
            fail_count = 0;
        endfunction

        function void pop_head();
            head  = (head + 1) % QUEUE_DEPTH;
            count = count - 1;
        endfunction

        function void note_item(tmexp_pkg::in_item_t beat);
            tmexp_pkg::out_item_t status;
            status = '0;
            case (beat.action)
                tmexp_pkg::ACT_TICK:
                begin
                    now_time = now_time + tmexp_pkg::STAMP_W'(beat.time_delta);
                    // expire from the head while the wrapped age is over the limit
                    while (count > 0 &&
                           (now_time - slots[head].stamp) > tmexp_pkg::STAMP_W'(duration))
                    begin
                        pop_head();
                    end
                end
                tmexp_pkg::ACT_ADD:
                begin
                    if (count >= QUEUE_DEPTH)
                    begin
                        status.add_dropped = 1'b1;
                    end
                    else
                    begin
                        slots[tail].kind  = beat.input_kind;
                        slots[tail].key   = beat.key_code;
                        slots[tail].stamp = now_time;
                        tail  = (tail + 1) % QUEUE_DEPTH;
                        count = count + 1;
                    end
                end
                tmexp_pkg::ACT_CHECK:
                begin
                    if (count > 0 && slots[head].kind == beat.input_kind &&
                        slots[head].key == beat.key_code)
                    begin
                        status.head_matched = 1'b1;
                        pop_head();
                    end
                end
                default:
                begin
                    head     = 0;
                    tail     = 0;
                    count    = 0;
                    now_time = '0;
                end
            endcase
            status.occupancy = tmexp_pkg::OCC_W'(count);
            pending_status.push_back(status);
        endfunction

        function void report(string what, tmexp_pkg::out_item_t want,
                             tmexp_pkg::out_item_t got);
            fail_count++;
            if (fail_count <= 10)
            begin
                $display("%s: expected matched=%0b dropped=%0b occupancy=%0d",
                         what, want.head_matched, want.add_dropped, want.occupancy);
                $display("%s: got matched=%0b dropped=%0b occupancy=%0d",
                         what, got.head_matched, got.add_dropped, got.occupancy);
            end
        endfunction

        function void check_status(tmexp_pkg::out_item_t got);
            tmexp_pkg::out_item_t want;
            if (pending_status.size() == 0)
            begin
                report("status beat with nothing pending", '0, got);
            end
            else
            begin
                want = pending_status.pop_front();
                if (got.head_matched !== want.head_matched ||
                    got.add_dropped !== want.add_dropped ||
                    got.occupancy !== want.occupancy)
                begin
                    report("status mismatch", want, got);
                end
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    tmexp_pkg::in_item_t           in_data;
    logic                          out_valid;
    logic                          out_ready;
    tmexp_pkg::out_item_t          out_data;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [tmexp_pkg::DUR_W-1:0]   cfg_data;

    expiry_scoreboard              sb;
    tmexp_pkg::in_item_t           directed_q [$];
    // sender side counts, each owned by one process
    int                            dir_sent;
    int                            rand_sent;
    int                            rand_total;
    // receiver hold-off requests and completions
    int                            hold_asked;
    int                            hold_done;
    bit                            calm;
    bit                            in_beat;
    int                            cycles;

    timed_input_expiry_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // sample every handshake at the rising edge, before the block updates
    always @(posedge clk)
    begin
        in_beat = rst_n && in_valid && in_ready;
        if (in_beat)
        begin
            sb.note_item(in_data);
        end
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_status(out_data);
        end
        if (rst_n && cfg_valid && cfg_ready)
        begin
            sb.duration = cfg_data;
        end
    end

    function automatic tmexp_pkg::in_item_t make_item(
        logic [tmexp_pkg::ACT_W-1:0] act,
        int unsigned                 delta,
        int unsigned                 kind,
        int unsigned                 key
    );
        tmexp_pkg::in_item_t beat;
        beat.action     = act;
        beat.time_delta = tmexp_pkg::DELTA_W'(delta);
        beat.input_kind = tmexp_pkg::KIND_W'(kind);
        beat.key_code   = tmexp_pkg::KEY_W'(key);
        return beat;
    endfunction

    // random item built from the current predicted queue, so checks can hit the head
    function automatic tmexp_pkg::in_item_t next_stim();
        tmexp_pkg::in_item_t beat;
        int unsigned         pick;
        int unsigned         span;
        beat.time_delta = tmexp_pkg::DELTA_W'($urandom);
        beat.input_kind = tmexp_pkg::KIND_W'($urandom);
        beat.key_code   = tmexp_pkg::KEY_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            beat.action = tmexp_pkg::ACT_TICK;
            // one in three deltas on the scale of the duration so expiry lands in the middle
            span = (sb.duration < 32768) ? 2 * sb.duration : 65535;
            case ($urandom_range(2))
                0:       beat.time_delta = tmexp_pkg::DELTA_W'($urandom_range(15));
                1:       beat.time_delta = tmexp_pkg::DELTA_W'($urandom_range(span));
                default: beat.time_delta = tmexp_pkg::DELTA_W'($urandom);
            endcase
        end
        else if (pick < 65)
        begin
            beat.action = tmexp_pkg::ACT_ADD;
        end
        else if (pick < 96)
        begin
            beat.action = tmexp_pkg::ACT_CHECK;
            if (sb.count > 0 && $urandom_range(9) < 6)
            begin
                beat.input_kind = sb.slots[sb.head].kind;
                beat.key_code   = sb.slots[sb.head].key;
                // near miss on one key bit
                if ($urandom_range(4) == 0)
                begin
                    beat.key_code[$urandom_range(tmexp_pkg::KEY_W-1)] ^= 1'b1;
                end
            end
        end
        else
        begin
            beat.action = tmexp_pkg::ACT_CLEAR;
        end
        return beat;
    endfunction

    // input driver: holds an offered beat until taken, then offers the next or idles
    initial
    begin
        in_valid  = 1'b0;
        in_data   = '0;
        dir_sent  = 0;
        rand_sent = 0;
        forever
        begin
            @(negedge clk);
            if (rst_n && !(in_valid && !in_beat))
            begin
                if ((dir_sent < directed_q.size() || rand_sent < rand_total) &&
                    (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    in_valid <= 1'b1;
                    if (dir_sent < directed_q.size())
                    begin
                        in_data  <= directed_q[dir_sent];
                        dir_sent  = dir_sent + 1;
                    end
                    else
                    begin
                        in_data   <= next_stim();
                        rand_sent  = rand_sent + 1;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver: random stalls, or one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        hold_done = 0;
        forever
        begin
            @(negedge clk);
            if (hold_done != hold_asked)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = hold_asked;
            end
            else
            begin
                out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // global watchdog
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    task automatic write_duration(logic [tmexp_pkg::DUR_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // the test pauses here until every status beat has come back
    task automatic drain_all();
        while (rand_sent < rand_total || dir_sent < directed_q.size() || in_valid)
        begin
            @(posedge clk);
        end
        while (sb.pending_status.size() > 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic run_phase(logic [tmexp_pkg::DUR_W-1:0] dur, int items, bit stall_out,
                             bit quiet);
        write_duration(dur);
        calm = quiet;
        if (stall_out)
        begin
            hold_asked = hold_asked + 1;
        end
        rand_total = rand_total + items;
        drain_all();
        calm = 1'b0;
    endtask

    task automatic run_directed();
        int k;
        write_duration(tmexp_pkg::DUR_W'(10));
        // check on an empty queue, tick of zero on an empty queue
        directed_q.push_back(make_item(tmexp_pkg::ACT_CHECK, 16'hffff, 7, 16'hffff));
        directed_q.push_back(make_item(tmexp_pkg::ACT_TICK, 0, 7, 16'hffff));
        directed_q.push_back(make_item(tmexp_pkg::ACT_ADD, 16'hffff, 0, 0));
        directed_q.push_back(make_item(tmexp_pkg::ACT_ADD, 0, 7, 16'hffff));
        // head is 0/0, so a check for the second entry misses, then the head hits
        directed_q.push_back(make_item(tmexp_pkg::ACT_CHECK, 0, 7, 16'hffff));
        directed_q.push_back(make_item(tmexp_pkg::ACT_CHECK, 16'hffff, 0, 0));
        // age equal to the duration is kept, one more unit expires it
        directed_q.push_back(make_item(tmexp_pkg::ACT_TICK, 10, 0, 0));
        directed_q.push_back(make_item(tmexp_pkg::ACT_TICK, 1, 7, 16'hffff));
        // fill the queue, then an add that is dropped
        for (k = 0; k < QUEUE_DEPTH; k++)
        begin
            directed_q.push_back(make_item(tmexp_pkg::ACT_ADD, $urandom, $urandom,
                                           $urandom));
        end
        directed_q.push_back(make_item(tmexp_pkg::ACT_ADD, 16'h5a5a, 5, 16'h1234));
        // largest delta expires the whole full queue in one tick
        directed_q.push_back(make_item(tmexp_pkg::ACT_TICK, 16'hffff, 0, 0));
        directed_q.push_back(make_item(tmexp_pkg::ACT_ADD, 0, 3, 16'h00ff));
        directed_q.push_back(make_item(tmexp_pkg::ACT_CLEAR, 16'hffff, 7, 16'hffff));
        drain_all();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        calm       = 1'b0;
        hold_asked = 0;
        rand_total = 0;
        sb         = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        // zero duration: anything older than now expires on the next tick
        run_phase('0, 130, 1'b0, 1'b0);
        // largest duration: nothing expires, the queue fills and drops adds
        run_phase(DUR_MAX, 120, 1'b0, 1'b0);
        // receiver holds off while the sender keeps offering beats
        run_phase(tmexp_pkg::DUR_W'(100), 160, 1'b1, 1'b0);
        // no idling on either side
        run_phase(tmexp_pkg::DUR_W'(5000), 150, 1'b0, 1'b1);
        // random duration with a full pause halfway through
        run_phase(tmexp_pkg::DUR_W'($urandom_range(200000)), 75, 1'b0, 1'b0);
        rand_total = rand_total + 75;
        drain_all();
        run_phase(tmexp_pkg::DUR_W'($urandom), 140, 1'b0, 1'b0);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.fail_count == 0 && sb.pending_status.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
